FILE: rtl/tank_level_reporter_assert.svh
// Assertion macros shared by the tank level reporter RTL.
`ifndef TANK_LEVEL_REPORTER_ASSERT_SVH
`define TANK_LEVEL_REPORTER_ASSERT_SVH

`ifndef SYNTHESIS

// Check on every clock edge outside reset; expects clk and rst_n in scope.
`define TLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check on every clock edge, reset included; expects clk in scope.
`define TLR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`else

`define TLR_ASSERT(lbl, prop, msg)
`define TLR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/tlr_pkg.sv
// Types, constants and fill tables of the tank level reporter.
`default_nettype none

package tlr_pkg;

    // Field widths
    localparam int ECHO_W    = 16;
    localparam int ALPHA_W   = 16;
    localparam int RADIUS_W  = 8;
    localparam int THR_W     = 7;
    localparam int WL_W      = 5;
    localparam int DIST_W    = 27;
    localparam int SUM_W     = 31;
    localparam int CNT_W     = 4;
    localparam int PCT_W     = 15;
    localparam int REP_W     = 7;
    localparam int MEAN_W    = 11;
    localparam int ENTRY_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Window sum above the Q.16 point, the only part the mean needs
    localparam int SUM_HI_W       = SUM_W - 16;
    localparam int DIV_RADIX_BITS = 5;
    localparam int DIV_CYCLES     = SUM_HI_W / DIV_RADIX_BITS;
    localparam int DIV_STEP_W     = $clog2(DIV_CYCLES);

    // Level table
    localparam int TABLE_DEPTH = 100;
    localparam int ROM_SIZE    = 100;
    localparam int IDX_W       = RADIUS_W;
    localparam int ROM_SPAN    = 2 ** IDX_W;
    localparam int DIFF_W      = RADIUS_W + 4;

    // Arithmetic constants
    localparam logic [10:0] DIST_SCALE  = 11'd1124;
    localparam int          FULL_ENTRY  = 1414;
    localparam int          PCT_SCALE   = 25600;
    localparam logic [16:0] GAIN_ONE    = 17'd65536;
    localparam logic [15:0] ROUND_HALF  = 16'd32768;
    localparam logic [WL_W-1:0] WL_MAX  = 5'd16;
    localparam logic [WL_W-1:0] WL_MIN  = 5'd1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA       = 3'd0,
        CFG_TANK_RADIUS = 3'd1,
        CFG_THRESHOLD   = 3'd2,
        CFG_WINDOW      = 3'd3
    } cfg_idx_t;

    // Register reset values
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd3277;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 8'd100;
    localparam logic [THR_W-1:0]    THR_RST    = 7'd2;
    localparam logic [WL_W-1:0]     WL_RST     = 5'd10;

    typedef struct packed {
        logic [ECHO_W-1:0] echo_time_us;
        logic              link_ready;
    } in_item_t;

    typedef struct packed {
        logic              send_report;
        logic [REP_W-1:0]  report_percent;
        logic              out_of_range;
        logic [PCT_W-1:0]  fill_percent_q8;
        logic [MEAN_W-1:0] mean_distance_cm;
    } out_item_t;

    // One finished window, handed from front to back
    typedef struct packed {
        logic [SUM_HI_W-1:0] sum_hi;
        logic [WL_W-1:0]     wl;
        logic                link;
    } win_t;

    localparam logic [ENTRY_W-1:0] LEVEL_TABLE [ROM_SIZE] = '{
        11'd2, 11'd7, 11'd12, 11'd19, 11'd26, 11'd35, 11'd44, 11'd53, 11'd63, 11'd74,
        11'd85, 11'd96, 11'd108, 11'd120, 11'd133, 11'd146, 11'd159, 11'd173, 11'd187,
        11'd201, 11'd216, 11'd231, 11'd246, 11'd261, 11'd276, 11'd292, 11'd308,
        11'd324, 11'd340, 11'd357, 11'd373, 11'd390, 11'd407, 11'd424, 11'd441,
        11'd458, 11'd476, 11'd493, 11'd510, 11'd528, 11'd546, 11'd563, 11'd581,
        11'd599, 11'd617, 11'd635, 11'd653, 11'd671, 11'd689, 11'd707, 11'd725,
        11'd743, 11'd761, 11'd779, 11'd797, 11'd815, 11'd832, 11'd850, 11'd868,
        11'd886, 11'd903, 11'd921, 11'd938, 11'd956, 11'd973, 11'd990, 11'd1007,
        11'd1024, 11'd1040, 11'd1057, 11'd1073, 11'd1090, 11'd1106, 11'd1122,
        11'd1137, 11'd1153, 11'd1168, 11'd1183, 11'd1198, 11'd1212, 11'd1227,
        11'd1241, 11'd1254, 11'd1268, 11'd1281, 11'd1293, 11'd1306, 11'd1318,
        11'd1329, 11'd1340, 11'd1351, 11'd1361, 11'd1370, 11'd1379, 11'd1387,
        11'd1395, 11'd1401, 11'd1407, 11'd1411, 11'd1414
    };

    typedef logic [PCT_W-1:0] pct_rom_t [ROM_SPAN];

    // Fill percent in Q7.8 for every index, rounded half up; zero past the table
    function automatic pct_rom_t build_pct_rom();
        pct_rom_t rom;
        int unsigned num;
        for (int i = 0; i < ROM_SPAN; i++) begin
            rom[i] = '0;
            if (i < ROM_SIZE) begin
                num    = int'(LEVEL_TABLE[i]) * PCT_SCALE + FULL_ENTRY / 2;
                rom[i] = PCT_W'(num / FULL_ENTRY);
            end
        end
        return rom;
    endfunction

    localparam pct_rom_t PCT_ROM = build_pct_rom();

endpackage

`default_nettype wire

FILE: rtl/tank_level_reporter.sv
// Top level of the tank level reporter: registers, front, queue and back.
//
//  Channel  | Handshake            | Beat payload
//  ---------+----------------------+--------------------------------------------
//  sample   | push / full          | echo_time_us, link_ready
//  result   | pop / empty          | send_report, report_percent, out_of_range,
//           |                      | fill_percent_q8, mean_distance_cm
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Each sample beat passes through the front in order: echo-to-distance multiply,
// the two filter multiplies, the rounding add and the window sum update.
// A closing window then passes through the back: queue pop, a restoring divide at
// 5 quotient bits per step, table lookup and report decision.
// A 2-entry window queue lets the front keep taking samples while the back
// waits on a result that has not been popped yet.
// Reset clears the control state at once; there is no clearing pass. cfg_ready is always high.
`default_nettype none

module tank_level_reporter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  tlr_pkg::in_item_t                   sample,
    output logic                                empty,
    input  wire logic                           pop,
    output tlr_pkg::out_item_t                  result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tlr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlr_pkg::CFG_DAT_W-1:0]  cfg_data
);

    logic [tlr_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [tlr_pkg::RADIUS_W-1:0] radius_reg;
    logic [tlr_pkg::THR_W-1:0]    thr_reg;
    logic [tlr_pkg::WL_W-1:0]     wl_reg;
    logic [tlr_pkg::WL_W-1:0]     wl_eff;

    logic           q_wr, q_full, q_rd, q_empty;
    tlr_pkg::win_t  q_wr_data, q_rd_data;

    // Config channel never stalls
    assign cfg_ready = 1'b1;

    // Clamp window length: zero acts as one, anything past sixteen as sixteen
    assign wl_eff = (wl_reg == '0)            ? tlr_pkg::WL_MIN :
                    (wl_reg > tlr_pkg::WL_MAX) ? tlr_pkg::WL_MAX : wl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= tlr_pkg::ALPHA_RST;
            radius_reg <= tlr_pkg::RADIUS_RST;
            thr_reg    <= tlr_pkg::THR_RST;
            wl_reg     <= tlr_pkg::WL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tlr_pkg::CFG_ALPHA:       alpha_reg  <= cfg_data[tlr_pkg::ALPHA_W-1:0];
                tlr_pkg::CFG_TANK_RADIUS: radius_reg <= cfg_data[tlr_pkg::RADIUS_W-1:0];
                tlr_pkg::CFG_THRESHOLD:   thr_reg    <= cfg_data[tlr_pkg::THR_W-1:0];
                tlr_pkg::CFG_WINDOW:      wl_reg     <= cfg_data[tlr_pkg::WL_W-1:0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Front: take sample beats, filter, accumulate, hand off closed windows
    tlr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .sample (sample),
        .alpha  (alpha_reg),
        .wl     (wl_eff),
        .q_wr   (q_wr),
        .q_data (q_wr_data),
        .q_full (q_full)
    );

    // Queue: decouple window production from report generation
    tlr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Back: average, look up fill percent, decide and hold the result beat
    tlr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_data           (q_rd_data),
        .q_rd             (q_rd),
        .tank_radius      (radius_reg),
        .change_threshold (thr_reg),
        .empty            (empty),
        .pop              (pop),
        .result           (result)
    );

endmodule

`default_nettype wire

FILE: rtl/tlr_queue.sv
// Short window queue between the front and back sections.
`default_nettype none

`include "tank_level_reporter_assert.svh"

module tlr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  tlr_pkg::win_t      wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output tlr_pkg::win_t      rd_data,
    output logic               empty
);

    localparam int PTR_W = (tlr_pkg::QUEUE_DEPTH > 1) ? $clog2(tlr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tlr_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(tlr_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(tlr_pkg::QUEUE_DEPTH - 1);

    tlr_pkg::win_t    slot_reg [tlr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `TLR_ASSERT(a_queue_count_bound, count_reg <= DEPTH_C, "queue count above depth")

endmodule

`default_nettype wire

FILE: rtl/tlr_front.sv
// Front section: distance conversion, low-pass filter and window summation.
`default_nettype none

`include "tank_level_reporter_assert.svh"

module tlr_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  tlr_pkg::in_item_t                 sample,
    input  wire logic [tlr_pkg::ALPHA_W-1:0]  alpha,
    input  wire logic [tlr_pkg::WL_W-1:0]     wl,
    output logic                              q_wr,
    output tlr_pkg::win_t                     q_data,
    input  wire logic                         q_full
);

    localparam int GAIN_W = tlr_pkg::ALPHA_W + 1;
    localparam int PROD_W = GAIN_W + tlr_pkg::DIST_W;
    localparam int ACC_W  = PROD_W + 1;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL1 = 5'b00010,
        F_MUL2 = 5'b00100,
        F_ACC  = 5'b01000,
        F_SUM  = 5'b10000
    } fstate_t;

    fstate_t                           state_reg, state_next;
    logic [tlr_pkg::ECHO_W-1:0]        echo_reg;
    logic                              link_reg;
    logic [tlr_pkg::DIST_W-1:0]        dist_reg;
    logic [PROD_W-1:0]                 p_new_reg, p_old_reg;
    logic [tlr_pkg::DIST_W-1:0]        filt_reg, filt_next;
    logic [tlr_pkg::SUM_W-1:0]         sum_reg, sum_next, sum_add;
    logic [tlr_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [tlr_pkg::CNT_W:0]           cnt_inc;
    logic [GAIN_W-1:0]                 gain_new, gain_old;
    logic [ACC_W-1:0]                  acc;
    logic                              win_end;

    assign full     = (state_reg != F_IDLE);
    assign gain_new = {1'b0, alpha};
    assign gain_old = tlr_pkg::GAIN_ONE - gain_new;
    assign acc      = ACC_W'(p_new_reg) + ACC_W'(p_old_reg) + ACC_W'(tlr_pkg::ROUND_HALF);
    assign sum_add  = tlr_pkg::SUM_W'(sum_reg + tlr_pkg::SUM_W'(filt_reg));
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign win_end  = (cnt_inc >= wl);
    assign q_data   = '{sum_hi: sum_add[tlr_pkg::SUM_W-1:16], wl: wl, link: link_reg};
    assign q_wr     = (state_reg == F_SUM) && win_end && !q_full;

    always_comb
    begin
        state_next = state_reg;
        filt_next  = filt_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    state_next = F_MUL1;
                end
            end
            F_MUL1:
            begin
                state_next = F_MUL2;
            end
            F_MUL2:
            begin
                state_next = F_ACC;
            end
            F_ACC:
            begin
                filt_next  = acc[16 +: tlr_pkg::DIST_W];
                state_next = F_SUM;
            end
            F_SUM:
            begin
                // hold a finished window until the queue takes it; a partial window goes back to idle
                if (!win_end)
                begin
                    sum_next   = sum_add;
                    cnt_next   = cnt_inc[tlr_pkg::CNT_W-1:0];
                    state_next = F_IDLE;
                end
                else if (!q_full)
                begin
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            filt_reg  <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            filt_reg  <= filt_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            echo_reg <= sample.echo_time_us;
            link_reg <= sample.link_ready;
        end
        if (state_reg == F_MUL1)
        begin
            dist_reg <= tlr_pkg::DIST_W'(echo_reg * tlr_pkg::DIST_SCALE);
        end
        if (state_reg == F_MUL2)
        begin
            p_new_reg <= PROD_W'(gain_new * dist_reg);
            p_old_reg <= PROD_W'(gain_old * filt_reg);
        end
    end

    `TLR_ASSERT(a_front_sum_done, state_reg == F_SUM && !win_end |=> state_reg == F_IDLE, "front held a partial window")

endmodule

`default_nettype wire

FILE: rtl/tlr_back.sv
// Back section: window mean, fill lookup and report decision.
`default_nettype none

`include "tank_level_reporter_assert.svh"

module tlr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  tlr_pkg::win_t                      q_data,
    output logic                               q_rd,
    input  wire logic [tlr_pkg::RADIUS_W-1:0]  tank_radius,
    input  wire logic [tlr_pkg::THR_W-1:0]     change_threshold,
    output logic                               empty,
    input  wire logic                          pop,
    output tlr_pkg::out_item_t                 result
);

    localparam int SW = tlr_pkg::SUM_HI_W;
    localparam int RW = tlr_pkg::WL_W;
    localparam logic [tlr_pkg::DIV_STEP_W-1:0] LAST_STEP =
        tlr_pkg::DIV_STEP_W'(tlr_pkg::DIV_CYCLES - 1);
    localparam logic [tlr_pkg::DIFF_W-1:0] DEPTH_C = tlr_pkg::DIFF_W'(tlr_pkg::TABLE_DEPTH);
    localparam logic [tlr_pkg::PCT_W-1:0]  PCT_FULL = tlr_pkg::PCT_W'(tlr_pkg::PCT_SCALE);
    localparam logic [tlr_pkg::REP_W-1:0]  REP_OOR  = 7'd1;

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_DIV    = 4'b0010,
        B_LOOK   = 4'b0100,
        B_DECIDE = 4'b1000
    } bstate_t;

    bstate_t                           state_reg, state_next;
    logic [tlr_pkg::DIV_STEP_W-1:0]    step_reg;
    logic [SW-1:0]                     quo_reg, quo_div;
    logic [RW-1:0]                     rem_reg, rem_div;
    logic [RW-1:0]                     wl_reg;
    logic                              link_reg;
    logic [tlr_pkg::MEAN_W-1:0]        mean_reg;
    logic [tlr_pkg::PCT_W-1:0]         pct_reg;
    logic                              in_table_reg;
    logic [tlr_pkg::PCT_W-1:0]         last_pct_reg, last_pct_next;
    logic                              reported_reg, reported_next;
    logic                              out_valid_reg, out_valid_next;
    tlr_pkg::out_item_t                out_reg, out_next;

    logic [SW-1:0]                     q_w;
    logic [RW-1:0]                     r_w;
    logic [RW:0]                       t_w;
    logic [tlr_pkg::MEAN_W-1:0]        mean_w;
    logic [tlr_pkg::DIFF_W-1:0]        idx_w;
    logic                              in_table_w;
    logic                              oor_w;
    logic [tlr_pkg::PCT_W-1:0]         diff_w;
    logic [tlr_pkg::PCT_W-1:0]         thr_w;
    logic                              change_w;
    logic                              slot_free;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign q_rd      = (state_reg == B_IDLE) && !q_empty;
    assign slot_free = !out_valid_reg || pop;

    // Restoring divide of the window sum by the window length, DIV_RADIX_BITS quotient bits a cycle
    always_comb
    begin
        r_w = rem_reg;
        q_w = quo_reg;
        t_w = '0;
        for (int i = 0; i < tlr_pkg::DIV_RADIX_BITS; i++)
        begin
            t_w = {r_w, q_w[SW-1]};
            q_w = {q_w[SW-2:0], 1'b0};
            if (t_w >= {1'b0, wl_reg})
            begin
                r_w    = RW'(t_w - {1'b0, wl_reg});
                q_w[0] = 1'b1;
            end
            else
            begin
                r_w = t_w[RW-1:0];
            end
        end
        rem_div = r_w;
        quo_div = q_w;
    end

    assign mean_w     = quo_reg[tlr_pkg::MEAN_W-1:0];
    assign idx_w      = tlr_pkg::DIFF_W'(tank_radius) - tlr_pkg::DIFF_W'(mean_w);
    assign in_table_w = !idx_w[tlr_pkg::DIFF_W-1] && (idx_w < DEPTH_C);

    assign oor_w    = !in_table_reg || (pct_reg == '0) || (pct_reg >= PCT_FULL);
    assign diff_w   = (pct_reg > last_pct_reg) ? tlr_pkg::PCT_W'(pct_reg - last_pct_reg)
                                               : tlr_pkg::PCT_W'(last_pct_reg - pct_reg);
    assign thr_w    = {change_threshold, 8'd0};
    assign change_w = (diff_w > thr_w) || !reported_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_pct_next  = last_pct_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = B_LOOK;
                end
            end
            B_LOOK:
            begin
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                // hold the decision until the output slot frees up
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_next.out_of_range     = oor_w;
                    out_next.fill_percent_q8  = pct_reg;
                    out_next.mean_distance_cm = mean_reg;
                    out_next.send_report      = 1'b0;
                    out_next.report_percent   = '0;
                    if (oor_w)
                    begin
                        out_next.send_report    = 1'b1;
                        out_next.report_percent = REP_OOR;
                        reported_next           = 1'b0;
                    end
                    else if (change_w)
                    begin
                        out_next.send_report    = 1'b1;
                        out_next.report_percent = pct_reg[tlr_pkg::PCT_W-1:8];
                        reported_next           = link_reg;
                        last_pct_next           = pct_reg;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            last_pct_reg  <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_pct_reg  <= last_pct_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == B_DIV)
            begin
                step_reg <= (step_reg == LAST_STEP) ? '0
                                                    : tlr_pkg::DIV_STEP_W'(step_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (q_rd)
        begin
            quo_reg  <= q_data.sum_hi;
            rem_reg  <= '0;
            wl_reg   <= q_data.wl;
            link_reg <= q_data.link;
        end
        else if (state_reg == B_DIV)
        begin
            quo_reg <= quo_div;
            rem_reg <= rem_div;
        end
        if (state_reg == B_LOOK)
        begin
            mean_reg     <= mean_w;
            in_table_reg <= in_table_w;
            pct_reg      <= in_table_w ? tlr_pkg::PCT_ROM[idx_w[tlr_pkg::IDX_W-1:0]] : '0;
        end
    end

    `TLR_ASSERT(a_back_step_bound, state_reg == B_DIV |-> step_reg <= LAST_STEP, "divide step past last")
    `TLR_ASSERT(a_back_reported_pct, reported_reg |-> last_pct_reg != '0, "reported flag with zero percent")

endmodule

`default_nettype wire
